// ===== hw/rtl/ntc_thermistor_temperature_top_macros.svh =====
// Assertion macros shared by the thermistor block.
// Each takes a label, the clock, the reset, a condition and a consequence.
`ifndef NTC_THERMISTOR_TEMPERATURE_TOP_MACROS_SVH
`define NTC_THERMISTOR_TEMPERATURE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntc assertion failed");
`define NTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntc assertion failed");
`else
`define NTC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NTC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/ntc_pkg.sv =====
package ntc_pkg;

   localparam int TABLE_ENTRIES = 110;
   localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

   localparam int SAMPLE_W   = 12;
   localparam int MEAN_W     = 12;
   localparam int SUM_W      = 16;
   localparam int COUNT_W    = 4;
   localparam int WINDOW_LEN = 10;
   localparam int MEAN_SHIFT = 3;
   localparam int REF_W      = 12;
   localparam int SERIES_W   = 8;
   localparam int TEMP_W     = 7;
   localparam int RES_W      = 12;
   localparam int NUM_W      = SERIES_W + REF_W;
   localparam int DIV_DW     = 24;
   localparam int DIV_VW     = 16;

   localparam logic [DIV_VW-1:0] ADC_FULL_SCALE = 16'd4095;

   // Thermistor resistance in tenths of a kilohm, one entry per degree from 0 C.
   localparam logic [RES_W-1:0] RES_TABLE [TABLE_ENTRIES] = '{
      12'd3270, 12'd3107, 12'd2954, 12'd2809, 12'd2672, 12'd2542, 12'd2419, 12'd2303,
      12'd2194, 12'd2090, 12'd1992, 12'd1898, 12'd1810, 12'd1726, 12'd1647, 12'd1572,
      12'd1500, 12'd1433, 12'd1368, 12'd1307, 12'd1249, 12'd1194, 12'd1142, 12'd1092,
      12'd1045, 12'd1000, 12'd957,  12'd916,  12'd877,  12'd840,  12'd805,  12'd771,
      12'd739,  12'd709,  12'd680,  12'd652,  12'd625,  12'd600,  12'd576,  12'd553,
      12'd531,  12'd510,  12'd490,  12'd471,  12'd453,  12'd435,  12'd418,  12'd402,
      12'd387,  12'd372,  12'd358,  12'd345,  12'd332,  12'd320,  12'd308,  12'd297,
      12'd286,  12'd275,  12'd265,  12'd256,  12'd247,  12'd238,  12'd229,  12'd221,
      12'd214,  12'd206,  12'd199,  12'd192,  12'd185,  12'd179,  12'd173,  12'd167,
      12'd161,  12'd156,  12'd151,  12'd146,  12'd141,  12'd136,  12'd132,  12'd127,
      12'd123,  12'd119,  12'd115,  12'd112,  12'd108,  12'd105,  12'd101,  12'd98,
      12'd95,   12'd92,   12'd89,   12'd87,   12'd84,   12'd81,   12'd79,   12'd76,
      12'd74,   12'd72,   12'd70,   12'd68,   12'd66,   12'd64,   12'd62,   12'd60,
      12'd58,   12'd57,   12'd55,   12'd53,   12'd52,   12'd50
   };

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hw/rtl/ntc_ram.sv =====
module ntc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 110
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ntc_div.sv =====
`include "ntc_thermistor_temperature_top_macros.svh"

module ntc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ntc_pkg::DIV_DW-1:0]  dividend,
   input  logic [ntc_pkg::DIV_VW-1:0]  divisor,
   output logic [ntc_pkg::DIV_DW-1:0]  quotient,
   output ntc_pkg::div_status_type     status
);

   import ntc_pkg::*;

   localparam int CNT_W = $clog2(DIV_DW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_VW-1:0] rem_ff, rem_in;
   logic [DIV_VW-1:0] div_ff, div_in;
   logic [DIV_VW:0]   part;
   logic [DIV_VW:0]   diff;
   logic              ge;

   // Restoring division, one quotient bit per cycle, dividend bits shifted in from the top.
   assign part = {rem_ff, quo_ff[DIV_DW-1]};
   assign diff = part - {1'b0, div_ff};
   assign ge   = (part >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_VW-1:0] : part[DIV_VW-1:0];
         quo_in = {quo_ff[DIV_DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `NTC_ASSERT_IMP(a_div_no_restart, clock, reset, start, !busy_ff)
   `NTC_ASSERT_IMP(a_div_rem_bound, clock, reset, busy_ff, rem_ff < div_ff)
   `NTC_ASSERT_NXT(a_div_done_pulse, clock, reset, done_ff, !done_ff && !busy_ff)

endmodule

// ===== hw/rtl/ntc_window.sv =====
module ntc_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sample_valid,
   input  logic [ntc_pkg::SAMPLE_W-1:0]  sample,
   output logic                          last,
   output logic [ntc_pkg::MEAN_W-1:0]    mean
);

   import ntc_pkg::*;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic [SAMPLE_W-1:0] max_n, min_n;
   logic [SUM_W-1:0]    sum_n;
   logic [SUM_W-1:0]    trimmed;

   assign last  = (count_ff == COUNT_W'(WINDOW_LEN - 1));
   assign max_n = (sample >= max_ff) ? sample : max_ff;
   assign min_n = (sample <= min_ff) ? sample : min_ff;
   assign sum_n = sum_ff + SUM_W'(sample);
   // The extremes are two of the window's own samples, so this never goes negative.
   assign trimmed = sum_n - SUM_W'(max_n) - SUM_W'(min_n);

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      mean_in  = mean_ff;
      if (sample_valid) begin
         if (last) begin
            mean_in  = trimmed[MEAN_SHIFT +: MEAN_W];
            count_in = '0;
            sum_in   = '0;
            max_in   = '0;
            min_in   = '1;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_n;
            max_in   = max_n;
            min_in   = min_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         max_ff   <= '0;
         min_ff   <= '1;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
      end
      mean_ff <= mean_in;
   end

   assign mean = mean_ff;

endmodule

// ===== hw/rtl/ntc_thermistor_temperature_top.sv =====
// Thermistor thermometer: 12-bit converter samples are taken one per cycle in windows of
// ten, and at the end of each window the trimmed mean (sum less the largest and smallest
// sample, over eight) is turned into millivolts, then into divider resistance, and looked
// up in a 110-entry calibration table held in a RAM; one beat with the nearest degree and
// the resistance follows, or none when the divider is saturated or the resistance falls
// outside the table. After the tenth sample of a window no sample is taken while the
// window is worked on, nor while a finished beat waits for the receiver: a multiply and a
// fold by the full scale give the millivolts, a wait on the radix-2 divider gives the
// resistance, then the table RAM is scanned at one entry per cycle. After reset the
// table RAM is loaded from the package table, during which no sample is taken; register
// writes are taken at any time.
`include "ntc_thermistor_temperature_top_macros.svh"

module ntc_thermistor_temperature_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ntc_pkg::SAMPLE_W-1:0]  req_adc_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ntc_pkg::TEMP_W-1:0]    rsp_temperature_celsius,
   output logic [ntc_pkg::RES_W-1:0]     rsp_resistance_tenths_kohm,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   import ntc_pkg::*;

   localparam int RES_WIDE_W = DIV_DW + 4;
   localparam int FOLD_W     = REF_W + 1;

   typedef enum logic [0:0] {
      REG_REFERENCE_MV = 1'b0,
      REG_SERIES_KOHM  = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      S_FILL,
      S_IDLE,
      S_MUL,
      S_MV_DIV,
      S_CHECK,
      S_R_DIV,
      S_R_WAIT,
      S_RANGE,
      S_SEARCH,
      S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [TBL_AW-1:0]  fill_ff, fill_in;
   logic [TBL_AW-1:0]  idx_ff, idx_in;
   logic [REF_W-1:0]   ref_ff, ref_in;
   logic [SERIES_W-1:0] series_ff, series_in;
   logic [DIV_DW-1:0]  prod_ff, prod_in;
   logic [REF_W-1:0]   mv_ff, mv_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [REF_W-1:0]   den_ff, den_in;
   logic [RES_WIDE_W-1:0] res_wide_ff, res_wide_in;
   logic [RES_W-1:0]   res_ff, res_in;
   logic [RES_W-1:0]   prev_ff, prev_in;
   logic [TEMP_W-1:0]  temp_ff, temp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W-1:0]  rsp_temp_ff, rsp_temp_in;
   logic [RES_W-1:0]   rsp_res_ff, rsp_res_in;

   logic               req_accept;
   logic               csr_write;
   logic               win_last;
   logic [MEAN_W-1:0]  win_mean;
   logic               div_start;
   logic [DIV_DW-1:0]  div_dividend;
   logic [DIV_VW-1:0]  div_divisor;
   logic [DIV_DW-1:0]  div_quotient;
   div_status_type     div_status;
   logic               ram_we;
   logic [TBL_AW-1:0]  ram_raddr;
   logic [RES_W-1:0]   ram_rdata;
   logic [RES_W-1:0]   to_next;
   logic [RES_W-1:0]   to_this;
   logic [FOLD_W-1:0]  mv_fold;
   logic [REF_W-1:0]   mv_quo;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   ntc_window u_window (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (req_accept),
      .sample       (req_adc_sample),
      .last         (win_last),
      .mean         (win_mean)
   );

   ntc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   ntc_ram #(
      .WIDTH (RES_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff),
      .wr_data (RES_TABLE[fill_ff]),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      csr_prdata = '0;
      unique case (reg_index_type'(csr_paddr[2]))
         REG_REFERENCE_MV: csr_prdata = 32'(ref_ff);
         REG_SERIES_KOHM:  csr_prdata = 32'(series_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // The full scale is one less than 2^12, so the quotient is the upper half of the
   // product plus one whenever the two halves together reach the full scale. The
   // product stays below 4095 * 4096, so the sum of the halves never reaches twice that.
   assign mv_fold = FOLD_W'(prod_ff[REF_W +: REF_W]) + FOLD_W'(prod_ff[REF_W-1:0]);
   assign mv_quo  = prod_ff[REF_W +: REF_W] + REF_W'(mv_fold >= FOLD_W'(ADC_FULL_SCALE));

   assign to_next = res_ff - ram_rdata;
   assign to_this = prev_ff - res_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      ref_in       = ref_ff;
      series_in    = series_ff;
      prod_in      = prod_ff;
      mv_in        = mv_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      res_wide_in  = res_wide_ff;
      res_in       = res_ff;
      prev_in      = prev_ff;
      temp_in      = temp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_temp_in  = rsp_temp_ff;
      rsp_res_in   = rsp_res_ff;
      ram_we       = 1'b0;
      ram_raddr    = '0;
      div_start    = 1'b0;
      div_dividend = DIV_DW'(num_ff);
      div_divisor  = DIV_VW'(den_ff);

      if (csr_write) begin
         unique case (reg_index_type'(csr_paddr[2]))
            REG_REFERENCE_MV: ref_in    = csr_pwdata[REF_W-1:0];
            REG_SERIES_KOHM:  series_in = csr_pwdata[SERIES_W-1:0];
            default:          ref_in    = ref_ff;
         endcase
      end

      unique case (state_ff)
         S_FILL: begin
            ram_we  = 1'b1;
            fill_in = fill_ff + 1'b1;
            if (fill_ff == TBL_AW'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept && win_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = DIV_DW'(ref_ff) * DIV_DW'(win_mean);
            state_in = S_MV_DIV;
         end
         S_MV_DIV: begin
            mv_in    = mv_quo;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // A saturated divider (including a zero reference) gives no beat.
            if (mv_ff >= ref_ff) begin
               state_in = S_IDLE;
            end else begin
               num_in   = NUM_W'(series_ff) * NUM_W'(mv_ff);
               den_in   = ref_ff - mv_ff;
               state_in = S_R_DIV;
            end
         end
         S_R_DIV: begin
            div_start = 1'b1;
            state_in  = S_R_WAIT;
         end
         S_R_WAIT: begin
            if (div_status.done) begin
               res_wide_in = RES_WIDE_W'(div_quotient) * RES_WIDE_W'(10);
               state_in    = S_RANGE;
            end
         end
         S_RANGE: begin
            if ((res_wide_ff > RES_WIDE_W'(RES_TABLE[0])) ||
                (res_wide_ff < RES_WIDE_W'(RES_TABLE[TABLE_ENTRIES-1]))) begin
               state_in = S_IDLE;
            end else begin
               res_in    = res_wide_ff[RES_W-1:0];
               ram_raddr = '0;
               idx_in    = '0;
               state_in  = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // The RAM returns entry idx_ff this cycle; the next entry is fetched meanwhile.
            ram_raddr = (idx_ff == TBL_AW'(TABLE_ENTRIES - 1)) ? idx_ff : idx_ff + 1'b1;
            if (idx_ff == '0) begin
               prev_in = ram_rdata;
               idx_in  = idx_ff + 1'b1;
            end else if (ram_rdata <= res_ff) begin
               // Midway between two entries, the higher index wins.
               temp_in  = (to_this < to_next) ? TEMP_W'(idx_ff - 1'b1) : TEMP_W'(idx_ff);
               state_in = S_OUT;
            end else begin
               prev_in = ram_rdata;
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = temp_ff;
               rsp_res_in   = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         fill_ff      <= '0;
         idx_ff       <= '0;
         ref_ff       <= 12'd3297;
         series_ff    <= 8'd47;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         ref_ff       <= ref_in;
         series_ff    <= series_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      mv_ff       <= mv_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      res_wide_ff <= res_wide_in;
      res_ff      <= res_in;
      prev_ff     <= prev_in;
      temp_ff     <= temp_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_res_ff  <= rsp_res_in;
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_temperature_celsius    = rsp_temp_ff;
   assign rsp_resistance_tenths_kohm = rsp_res_ff;

   `NTC_ASSERT_IMP(a_temp_range, clock, reset, rsp_valid, rsp_temperature_celsius < TEMP_W'(TABLE_ENTRIES))
   `NTC_ASSERT_IMP(a_res_range, clock, reset, rsp_valid, (rsp_resistance_tenths_kohm >= RES_TABLE[TABLE_ENTRIES-1]) && (rsp_resistance_tenths_kohm <= RES_TABLE[0]))
   `NTC_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == S_SEARCH, idx_ff < TBL_AW'(TABLE_ENTRIES))
   `NTC_ASSERT_NXT(a_out_wait, clock, reset, (state_ff == S_OUT) && rsp_valid && !rsp_ready, state_ff == S_OUT)

endmodule

// ===== tb/sv/ntc_thermistor_temperature_top_tb.sv =====
`timescale 1ns / 100ps

module ntc_thermistor_temperature_top_tb;

   import ntc_pkg::*;

   localparam logic [2:0] ADDR_REFERENCE_MV = 3'd0;
   localparam logic [2:0] ADDR_SERIES_KOHM  = 3'd4;
   localparam int         DRAIN_CYCLES      = 250;
   localparam int         CYCLE_LIMIT       = 500000;
   localparam int         SAMPLE_MAX        = (1 << SAMPLE_W) - 1;
   localparam int         EDGE_TENTHS [7]   = '{0, 50, 60, 270, 500, 3270, 3300};

   typedef struct packed {
      logic [TEMP_W-1:0] celsius;
      logic [RES_W-1:0]  tenths;
   } reading_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_adc_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [TEMP_W-1:0]   rsp_temperature_celsius;
   logic [RES_W-1:0]    rsp_resistance_tenths_kohm;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // Thermometer state as the predictor sees it.
   logic [REF_W-1:0]    ref_mv = 12'd3297;
   logic [SERIES_W-1:0] series_kohm = 8'd47;
   logic [COUNT_W-1:0]  win_count = '0;
   logic [SUM_W-1:0]    win_sum = '0;
   logic [SAMPLE_W-1:0] win_max = '0;
   logic [SAMPLE_W-1:0] win_min = '1;

   logic [SAMPLE_W-1:0] pending_samples[$];
   reading_type         expected_readings[$];
   int                  queued_count = 0;
   int                  accepted_count = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;

   ntc_thermistor_temperature_top u_top (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_adc_sample             (req_adc_sample),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_temperature_celsius    (rsp_temperature_celsius),
      .rsp_resistance_tenths_kohm (rsp_resistance_tenths_kohm),
      .csr_psel                   (csr_psel),
      .csr_penable                (csr_penable),
      .csr_pwrite                 (csr_pwrite),
      .csr_paddr                  (csr_paddr),
      .csr_pwdata                 (csr_pwdata),
      .csr_prdata                 (csr_prdata),
      .csr_pready                 (csr_pready)
   );

   always #1 clock = ~clock;

   // Divider resistance in tenths of a kilohm for a given mean, or -1 when saturated.
   function automatic int divider_tenths(input int unsigned mean);
      int unsigned ref_v;
      int unsigned series_v;
      int unsigned mv;
      ref_v    = ref_mv;
      series_v = series_kohm;
      mv       = ref_v * mean / 32'(ADC_FULL_SCALE);
      if (mv >= ref_v) return -1;
      return int'(series_v * mv / (ref_v - mv) * 10);
   endfunction

   // Lowest steady sample whose resistance reaches the target under the current settings.
   function automatic logic [SAMPLE_W-1:0] sample_for_tenths(input int target);
      int tenths;
      for (int s = 0; s <= SAMPLE_MAX; s++) begin
         tenths = divider_tenths(s);
         if (tenths < 0 || tenths >= target) return SAMPLE_W'(s);
      end
      return SAMPLE_W'(SAMPLE_MAX);
   endfunction

   task automatic take_sample(input logic [SAMPLE_W-1:0] s);
      int unsigned mean;
      int          tenths;
      int          j;
      int          to_this;
      int          to_next;
      reading_type r;
      if (s >= win_max) win_max = s;
      if (s <= win_min) win_min = s;
      win_sum   = win_sum + SUM_W'(s);
      win_count = win_count + 1'b1;
      if (win_count == WINDOW_LEN) begin
         mean      = (32'(win_sum) - 32'(win_max) - 32'(win_min)) >> MEAN_SHIFT;
         win_count = '0;
         win_sum   = '0;
         win_max   = '0;
         win_min   = '1;
         tenths    = divider_tenths(mean);
         if (tenths >= int'(RES_TABLE[TABLE_ENTRIES-1]) && tenths <= int'(RES_TABLE[0])) begin
            // The table falls with index, so the first lower bound reached brackets it.
            j = 0;
            while (tenths < int'(RES_TABLE[j+1])) j++;
            to_this   = int'(RES_TABLE[j]) - tenths;
            to_next   = tenths - int'(RES_TABLE[j+1]);
            r.celsius = TEMP_W'((to_this < to_next) ? j : j + 1);
            r.tenths  = RES_W'(tenths);
            expected_readings.push_back(r);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_adc_sample <= pending_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : monitor
      reading_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            take_sample(req_adc_sample);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected result beat: celsius %0d, tenths %0d",
                      rsp_temperature_celsius, rsp_resistance_tenths_kohm);
               error_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temperature_celsius !== want.celsius) begin
                  $error("temperature_celsius: expected %0d, got %0d",
                         want.celsius, rsp_temperature_celsius);
                  error_count++;
               end
               if (rsp_resistance_tenths_kohm !== want.tenths) begin
                  $error("resistance_tenths_kohm: expected %0d, got %0d",
                         want.tenths, rsp_resistance_tenths_kohm);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_REFERENCE_MV) ref_mv = value[REF_W-1:0];
      else series_kohm = value[SERIES_W-1:0];
   endtask

   task automatic push_sample(input int v);
      pending_samples.push_back(SAMPLE_W'(v));
      queued_count++;
   endtask

   // Mostly steady windows around a chosen resistance with a high and (unless at the same
   // position) a low outlier, which the trimming should drop; the rest is pure noise.
   task automatic fill_windows(input int count);
      int                  target;
      int                  hi_pos;
      int                  lo_pos;
      int                  v;
      logic [SAMPLE_W-1:0] base;
      for (int w = 0; w < count; w++) begin
         if ($urandom_range(99) < 15) begin
            for (int k = 0; k < WINDOW_LEN; k++) push_sample($urandom_range(0, SAMPLE_MAX));
         end else begin
            if ($urandom_range(9) == 0) target = EDGE_TENTHS[$urandom_range(0, 6)];
            else target = $urandom_range(40, 3400);
            base   = sample_for_tenths(target);
            hi_pos = $urandom_range(0, WINDOW_LEN - 1);
            lo_pos = $urandom_range(0, WINDOW_LEN - 1);
            for (int k = 0; k < WINDOW_LEN; k++) begin
               if (k == hi_pos) begin
                  v = $urandom_range(base, SAMPLE_MAX);
               end else if (k == lo_pos) begin
                  v = $urandom_range(0, base);
               end else begin
                  v = int'(base) + int'($urandom_range(0, 2)) - 1;
                  if (v < 0) v = 0;
                  if (v > SAMPLE_MAX) v = SAMPLE_MAX;
               end
               push_sample(v);
            end
         end
      end
   endtask

   // A window that gives no result can keep the block busy after the last reading,
   // so a drain period follows.
   task automatic settle();
      wait (accepted_count == queued_count && expected_readings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int reference, input int series, input int windows);
      settle();
      write_register(ADDR_REFERENCE_MV, reference);
      write_register(ADDR_SERIES_KOHM, series);
      fill_windows(windows);
   endtask

   initial begin
      logic [SAMPLE_W-1:0] s;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 17;
      stall_pct     = 58;

      // Directed: both extremes trimmed around a midway resistance, a saturated divider,
      // then the top of the table.
      s = sample_for_tenths(270);
      push_sample(0);
      for (int k = 0; k < 8; k++) push_sample(s);
      push_sample(SAMPLE_MAX);
      for (int k = 0; k < WINDOW_LEN; k++) push_sample(SAMPLE_MAX);
      s = sample_for_tenths(3270);
      for (int k = 0; k < WINDOW_LEN; k++) push_sample(s);
      fill_windows(30);

      run_phase(4095, 255, 30);
      run_phase(1, 1, 5);
      settle();
      send_idle_pct = 58;
      stall_pct     = 17;
      run_phase(4095, 1, 30);
      run_phase(1, 255, 5);
      run_phase($urandom_range(1000, 4095), $urandom_range(1, 255), 30);
      settle();
      send_idle_pct = 0;
      stall_pct     = 0;
      run_phase($urandom_range(1, 4095), $urandom_range(1, 255), 30);
      run_phase(3297, 47, 27);
      settle();

      if (error_count == 0) begin
         $display("ntc_thermistor_temperature_top_tb passed");
      end else begin
         $display("ntc_thermistor_temperature_top_tb failed");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("ntc_thermistor_temperature_top_tb failed");
      $finish;
   end

endmodule
